[sv/evad_pkg.sv]
// ----------------------------------------------------------------------------
// evad_pkg
// Shared constants for the energy voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int unsigned FrameSamples = 512;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned MagW         = 16;
  localparam int unsigned SqW          = 2 * MagW;
  localparam int unsigned SumW         = 41;
  localparam int unsigned AluW         = SumW + 1;
  localparam int unsigned CntW         = 13;
  localparam int unsigned RemW         = CntW;
  localparam int unsigned RunW         = 8;
  localparam int unsigned ThrW         = 31;
  localparam int unsigned MeanW        = 31;
  localparam int unsigned EvW          = 2;
  localparam int unsigned DivCntW      = 6;
  localparam int unsigned AddrW        = 4;
  localparam int unsigned DataW        = 32;
  localparam int unsigned OutDataW     = 40;

  localparam logic [RunW-1:0] RunMax = '1;

  localparam logic [ThrW-1:0] ThrReset     = ThrW'(5000);
  localparam logic [RunW-1:0] SpeechReset  = RunW'(3);
  localparam logic [RunW-1:0] SilenceReset = RunW'(15);

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegSpeechN   = 2'd1;
  localparam logic [1:0] RegSilenceN  = 2'd2;

  localparam logic [EvW-1:0] EvNone  = 2'd0;
  localparam logic [EvW-1:0] EvStart = 2'd1;
  localparam logic [EvW-1:0] EvEnd   = 2'd2;

endpackage

[sv/energy_vad_with_hangover_core.sv]
// ----------------------------------------------------------------------------
// energy_vad_with_hangover_core
// Frame energy voice activity detector with onset and hangover run counts.
// Each word passes accept, square and accumulate steps before the next is taken.
// Frame end runs a divide (one shared 42-bit adder, one quotient bit per cycle)
// then a decide step that waits for a free output; result word registered on m_axis.
// Reset: rst_ni async low, clears sums, counts, runs, state; config to defaults.
// ----------------------------------------------------------------------------
module energy_vad_with_hangover_core
  import evad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic                s_axis_tlast,   // last_in_frame
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [30:0] mean_power, [31] speech_active,
                                              // [33:32] event_res, [39:34] zero
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACC,
    ST_DIV,
    ST_DECIDE
  } state_e;

  state_e               state_q;
  logic [MagW-1:0]      mag_q;
  logic                 last_q;
  logic [SqW-1:0]       sq_q;
  logic [SumW-1:0]      sum_q;
  logic [CntW-1:0]      cnt_q;
  logic [RemW-1:0]      rem_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [RunW-1:0]      speech_run_q;
  logic [RunW-1:0]      silence_run_q;
  logic                 active_q;
  logic                 m_valid_q;
  logic [MeanW-1:0]     mean_q;
  logic                 act_out_q;
  logic [EvW-1:0]       ev_q;
  logic [ThrW-1:0]      thr_q;
  logic [RunW-1:0]      speech_n_q;
  logic [RunW-1:0]      silence_n_q;

  logic                 s_hs;
  logic                 cfg_wr;
  logic [MagW-1:0]      mag_d;
  logic [RemW:0]        rem_sh;
  logic [AluW-1:0]      alu_a;
  logic [AluW-1:0]      alu_b;
  logic                 alu_cin;
  logic [AluW-1:0]      alu_sum;
  logic                 div_ge;
  logic [CntW-1:0]      cnt_d;
  logic                 frame_end;
  logic                 loud_frame;
  logic [RunW-1:0]      speech_run_d;
  logic [RunW-1:0]      silence_run_d;
  logic                 active_d;
  logic [EvW-1:0]       ev_d;
  logic                 out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OutDataW - MeanW - 1 - EvW)'(0), ev_q, act_out_q, mean_q};
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // two's complement magnitude; -32768 maps to 0x8000
  assign mag_d = s_axis_tdata[SampleW-1] ? (~s_axis_tdata + MagW'(1)) : s_axis_tdata;

  // shared adder: accumulate or trial subtract
  assign rem_sh = {rem_q, sum_q[SumW-1]};
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a   = {(AluW - RemW - 1)'(0), rem_sh};
      alu_b   = ~{(AluW - CntW)'(0), cnt_q};
      alu_cin = 1'b1;
    end else begin
      alu_a   = {1'b0, sum_q};
      alu_b   = {(AluW - SqW)'(0), sq_q};
      alu_cin = 1'b0;
    end
    alu_sum = alu_a + alu_b + AluW'(alu_cin);
  end
  assign div_ge = !alu_sum[AluW-1];

  assign cnt_d     = cnt_q + CntW'(1);
  assign frame_end = last_q || (cnt_d >= CntW'(FrameSamples));

  always_comb begin
    loud_frame    = sum_q > {(SumW - ThrW)'(0), thr_q};
    speech_run_d  = speech_run_q;
    silence_run_d = silence_run_q;
    active_d      = active_q;
    ev_d          = EvNone;
    if (loud_frame) begin
      if (speech_run_q < RunMax) speech_run_d = speech_run_q + RunW'(1);
      silence_run_d = '0;
      if (speech_run_d >= speech_n_q && !active_q) begin
        active_d = 1'b1;
        ev_d     = EvStart;
      end
    end else begin
      if (silence_run_q < RunMax) silence_run_d = silence_run_q + RunW'(1);
      speech_run_d = '0;
      if (silence_run_d >= silence_n_q && active_q) begin
        active_d = 1'b0;
        ev_d     = EvEnd;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = {(DataW - ThrW)'(0), thr_q};
      RegSpeechN:   prdata = {(DataW - RunW)'(0), speech_n_q};
      RegSilenceN:  prdata = {(DataW - RunW)'(0), silence_n_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThrReset;
      speech_n_q  <= SpeechReset;
      silence_n_q <= SilenceReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegThreshold: thr_q       <= pwdata[ThrW-1:0];
        RegSpeechN:   speech_n_q  <= pwdata[RunW-1:0];
        RegSilenceN:  silence_n_q <= pwdata[RunW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      mag_q  <= mag_d;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_SQUARE) sq_q <= mag_q * mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sum_q         <= '0;
      cnt_q         <= '0;
      rem_q         <= '0;
      div_cnt_q     <= '0;
      speech_run_q  <= '0;
      silence_run_q <= '0;
      active_q      <= 1'b0;
      m_valid_q     <= 1'b0;
      mean_q        <= '0;
      act_out_q     <= 1'b0;
      ev_q          <= EvNone;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != ST_DECIDE) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_hs) state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          sum_q     <= alu_sum[AluW-1] ? '1 : alu_sum[SumW-1:0];
          cnt_q     <= cnt_d;
          rem_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= frame_end ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          rem_q     <= div_ge ? alu_sum[RemW-1:0] : rem_sh[RemW-1:0];
          sum_q     <= {sum_q[SumW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(SumW - 1)) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            speech_run_q  <= speech_run_d;
            silence_run_q <= silence_run_d;
            active_q      <= active_d;
            mean_q        <= sum_q[MeanW-1:0];
            act_out_q     <= active_d;
            ev_q          <= ev_d;
            m_valid_q     <= 1'b1;
            sum_q         <= '0;
            cnt_q         <= '0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && ev_q == EvStart) |-> act_out_q)
    else $error("start event with inactive flag");

  a_end_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && ev_q == EvEnd) |-> !act_out_q)
    else $error("end event with active flag");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FrameSamples))
    else $error("frame count beyond frame length");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready)
    else $error("ready while a word is in progress");

  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speech_run_q == '0) || (silence_run_q == '0))
    else $error("both run counters nonzero");
`endif

endmodule

[bench/tb_energy_vad_with_hangover_core.sv]
// ----------------------------------------------------------------------------
// tb_energy_vad_with_hangover_core
// Self-checking bench for the energy voice activity detector. Streams sample
// words in frames of mixed length and loudness and predicts every frame
// result: floored mean power, activity flag and start/end event. Covers run
// saturation, zero and maximal run lengths, threshold extremes, overlong
// frames and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_energy_vad_with_hangover_core;
  import evad_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 64;

  localparam int unsigned LvlSilent = 0;
  localparam int unsigned LvlQuiet  = 1;
  localparam int unsigned LvlLoud   = 2;
  localparam int unsigned LvlSpread = 3;

  typedef struct packed {
    logic [MeanW-1:0] mean_power;
    logic             speech_active;
    logic [EvW-1:0]   event_res;
  } frame_result_t;

  class vad_scoreboard;
    logic [ThrW-1:0] threshold;
    logic [RunW-1:0] speech_need;
    logic [RunW-1:0] silence_need;
    logic [SumW-1:0] energy;
    logic [CntW-1:0] count;
    logic [RunW-1:0] speech_run;
    logic [RunW-1:0] silence_run;
    logic            active;
    frame_result_t   frame_results_q[$];
    int unsigned     fails;

    function new();
      threshold    = ThrReset;
      speech_need  = SpeechReset;
      silence_need = SilenceReset;
      energy       = '0;
      count        = '0;
      speech_run   = '0;
      silence_run  = '0;
      active       = 1'b0;
      fails        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DataW-1:0] val);
      case (idx)
        RegThreshold: threshold    = val[ThrW-1:0];
        RegSpeechN:   speech_need  = val[RunW-1:0];
        RegSilenceN:  silence_need = val[RunW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SampleW-1:0] smp, logic last);
      logic [MagW-1:0]  mag;
      logic [SqW-1:0]   sq;
      logic [AluW-1:0]  acc;
      logic [SumW-1:0]  mean;
      logic [EvW-1:0]   ev;
      frame_result_t    res;
      mag = smp[SampleW-1] ? (~smp + 1'b1) : smp;
      sq  = mag * mag;
      acc = energy + sq;
      energy = acc[AluW-1] ? '1 : acc[SumW-1:0];
      count = count + 1'b1;
      if (!last && count < CntW'(FrameSamples)) return;
      mean = energy / count;
      ev = EvNone;
      if (mean > SumW'(threshold)) begin
        if (speech_run != RunMax) speech_run = speech_run + 1'b1;
        silence_run = '0;
        if (speech_run >= speech_need && !active) begin
          active = 1'b1;
          ev = EvStart;
        end
      end else begin
        if (silence_run != RunMax) silence_run = silence_run + 1'b1;
        speech_run = '0;
        if (silence_run >= silence_need && active) begin
          active = 1'b0;
          ev = EvEnd;
        end
      end
      res.mean_power    = mean[MeanW-1:0];
      res.speech_active = active;
      res.event_res     = ev;
      frame_results_q.push_back(res);
      energy = '0;
      count  = '0;
    endfunction

    function void check_frame_result(logic [OutDataW-1:0] word);
      frame_result_t want;
      if (frame_results_q.size() == 0) begin
        $error("unexpected result word %h", word);
        fails++;
        return;
      end
      want = frame_results_q.pop_front();
      if (word[MeanW-1:0] != want.mean_power) begin
        $error("mean_power: expected %0d, got %0d", want.mean_power, word[MeanW-1:0]);
        fails++;
      end
      if (word[MeanW] != want.speech_active) begin
        $error("speech_active: expected %0d, got %0d", want.speech_active, word[MeanW]);
        fails++;
      end
      if (word[MeanW+1 +: EvW] != want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, word[MeanW+1 +: EvW]);
        fails++;
      end
      if (word[OutDataW-1:MeanW+1+EvW] != '0) begin
        $error("tdata pad: expected 0, got %0h", word[OutDataW-1:MeanW+1+EvW]);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return frame_results_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata = '0;   // [15:0] sample
  logic                s_axis_tlast = 1'b0; // last_in_frame
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [30:0] mean_power, [31] speech_active,
                                            // [33:32] event_res, [39:34] zero
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  vad_scoreboard sb = new();
  int unsigned   samples_taken = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   sink_stall_pct = 0;

  energy_vad_with_hangover_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_sample(s_axis_tdata, s_axis_tlast);
      samples_taken++;
    end
    if (m_axis_tvalid && m_axis_tready) sb.check_frame_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] smp, input logic last);
    int unsigned taken0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = smp;
    s_axis_tlast  = last;
    taken0 = samples_taken;
    do @(negedge clk_i); while (samples_taken == taken0);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DataW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // sender holds off until every frame result is back and the core is quiet
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic configure(input logic [DataW-1:0] thr, input int unsigned sp,
                           input int unsigned si, input int unsigned src_pct,
                           input int unsigned sink_pct);
    drain();
    reg_write(RegThreshold, thr);
    reg_write(RegSpeechN, DataW'(sp));
    reg_write(RegSilenceN, DataW'(si));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  function automatic logic [SampleW-1:0] pick_sample(int unsigned level, int unsigned amp);
    int v;
    case (level)
      LvlSilent: v = 0;
      LvlQuiet:  v = int'($urandom_range(80)) - 40;
      LvlLoud:   v = int'($urandom_range(16'hFFFF)) - 32768;
      default:   v = int'($urandom_range(2 * amp)) - int'(amp);
    endcase
    return SampleW'(v);
  endfunction

  // frames in runs of like loudness so onset and hangover counts get exercised
  task automatic run_traffic(input int unsigned items);
    int unsigned sent, run_left, level, len, amp, r, i;
    sent = 0;
    run_left = 0;
    level = LvlQuiet;
    while (sent < items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 20);
        r = $urandom_range(99);
        level = (r < 10) ? LvlSilent : (r < 45) ? LvlQuiet : (r < 85) ? LvlLoud : LvlSpread;
      end
      run_left--;
      r = $urandom_range(99);
      len = (r < 85) ? $urandom_range(1, 6) : (r < 97) ? $urandom_range(7, 40) :
            $urandom_range(41, 120);
      amp = $urandom_range(32767);
      for (i = 0; i < len; i++) send_sample(pick_sample(level, amp), i == len - 1);
      sent += len;
    end
  endtask

  // one sample per frame, so run counters climb fast
  task automatic run_single_frames(input int unsigned frames, input bit nonzero);
    logic [SampleW-1:0] smp;
    int unsigned i;
    for (i = 0; i < frames; i++) begin
      do smp = SampleW'($urandom); while (nonzero && smp == '0);
      send_sample(smp, 1'b1);
    end
  endtask

  initial begin
    int unsigned i;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset config: extremes, onset after three loud frames
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd40, 1'b0);
    send_sample(-16'sd40, 1'b1);
    send_sample(16'sd70, 1'b0);
    send_sample(16'sd71, 1'b1);
    send_sample(-16'sd71, 1'b1);

    // zero threshold, longest onset: speech run saturates past 255
    configure(32'd0, 255, 0, 20, 20);
    run_single_frames(270, 1'b1);

    // top threshold, longest hangover: silence run saturates past 255
    configure(32'h4000_0000, 0, 255, 81, 0);
    run_single_frames(270, 1'b0);

    // zero run lengths: state follows every frame
    configure(32'd0, 0, 0, 0, 81);
    run_traffic(130);

    // mean equal to threshold is silence, one above is speech
    configure(32'd10000, 1, 1, 0, 0);
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd101, 1'b1);
    run_traffic(130);

    // overlong frame closes itself at the frame size
    configure(DataW'($urandom_range(20000)), $urandom_range(1, 8), $urandom_range(1, 20),
              20, 20);
    for (i = 0; i < FrameSamples + 3; i++) send_sample(pick_sample(LvlSpread, 30000), 1'b0);
    send_sample(pick_sample(LvlQuiet, 0), 1'b1);
    run_traffic(130);

    configure(DataW'(ThrReset), SpeechReset, SilenceReset, 81, 0);
    run_traffic(130);

    configure(DataW'($urandom_range(32'h4000_0000)), 2, 4, 0, 81);
    run_traffic(130);

    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
